// File: rtl/core/ppfa_pkg.sv
`default_nettype none

package ppfa_pkg;

  // default sizes
  localparam int unsigned MEM_WORDS_DEF = 65536;
  localparam int unsigned MAX_DIM_DEF   = 4096;

  // field widths
  localparam int unsigned DIM_W      = 13;
  localparam int unsigned FMT_W      = 3;
  localparam int unsigned X_W        = 12;
  localparam int unsigned Y_W        = 12;
  localparam int unsigned PIX_W      = 32;
  localparam int unsigned ST_W       = 2;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 13;
  localparam int unsigned OFF_W      = 14;   // byte offset inside a row
  localparam int unsigned PROD_W     = 25;   // row * row_words
  localparam int unsigned IDXW       = 26;   // full word index before range check

  // pixel formats
  localparam logic [FMT_W-1:0] FMT_1BPP  = 3'd0;
  localparam logic [FMT_W-1:0] FMT_4BPP  = 3'd1;
  localparam logic [FMT_W-1:0] FMT_8BPP  = 3'd2;
  localparam logic [FMT_W-1:0] FMT_16BPP = 3'd3;
  localparam logic [FMT_W-1:0] FMT_24BPP = 3'd4;
  localparam logic [FMT_W-1:0] FMT_32BPP = 3'd5;

  // request kinds
  localparam logic CMD_READ  = 1'b0;
  localparam logic CMD_WRITE = 1'b1;

  // result status
  localparam logic [ST_W-1:0] STATUS_OK      = 2'd0;
  localparam logic [ST_W-1:0] STATUS_OUTSIDE = 2'd1;
  localparam logic [ST_W-1:0] STATUS_BEYOND  = 2'd2;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_FORMAT = 2'd2;

  typedef struct packed {
    logic clr;
    logic capture;
    logic calc;
    logic check;
    logic rd_lo;
    logic rd_hi;
    logic cap_lo;
    logic modify;
    logic wr_lo;
    logic wr_hi;
    logic load_out;
  } ppfa_cmd_t;

  typedef struct packed {
    logic clr_last;
    logic err;
    logic span;
    logic is_write;
  } ppfa_stat_t;

  function automatic logic [PIX_W-1:0] fmt_mask(input logic [FMT_W-1:0] fmt);
    logic [PIX_W-1:0] m;
    unique case (fmt)
      FMT_1BPP:  m = 32'h0000_0001;
      FMT_4BPP:  m = 32'h0000_000f;
      FMT_8BPP:  m = 32'h0000_00ff;
      FMT_16BPP: m = 32'h0000_ffff;
      FMT_24BPP: m = 32'h00ff_ffff;
      default:   m = 32'hffff_ffff;
    endcase
    return m;
  endfunction

endpackage

`default_nettype wire

// File: rtl/core/packed_pixel_frame_access.sv
// sequence: capture, address, range check, read, modify, write back and result; a request
//   outside the frame or the store goes from the check to the result, and a straddling
//   24 bpp write adds a write of the upper word; one request at a time, held off by the
//   read-modify-write sequence on the frame store and by a result waiting for out_tready
// reset: synchronous, active low; control and config registers go to zero, then a clearing
//   pass zeroes every word of the store while in_tready stays low (config writes taken)
`default_nettype none

module packed_pixel_frame_access import ppfa_pkg::*; #(
  parameter int unsigned MEM_WORDS = MEM_WORDS_DEF,
  parameter int unsigned MAX_DIM   = MAX_DIM_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  // configuration writes
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  // request channel
  input  wire logic                  in_tvalid,
  output logic                       in_tready,
  input  wire logic [55:0]           in_tdata,   // pos_x[11:0], pos_y[23:12], write_value[55:24]
  input  wire logic                  in_tuser,   // command
  // result channel
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  output logic [31:0]                out_tdata,  // pixel_value[31:0]
  output logic [1:0]                 out_tuser   // status
);

  ppfa_cmd_t  cmd;
  ppfa_stat_t st;

  // registers are always writable; the user writes them only while idle
  assign cfg_ready = 1'b1;

  // sequencer: clearing pass, then one request at a time through the datapath
  ppfa_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .st         (st),
    .cmd        (cmd)
  );

  // address math, frame store and pixel pack/unpack
  ppfa_dp #(
    .MEM_WORDS (MEM_WORDS),
    .MAX_DIM   (MAX_DIM)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_valid & cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_cmd     (in_tuser),
    .in_x       (in_tdata[11:0]),
    .in_y       (in_tdata[23:12]),
    .in_value   (in_tdata[55:24]),
    .cmd        (cmd),
    .st         (st),
    .out_status (out_tuser),
    .out_pixel  (out_tdata)
  );

  // result only moves into the output register when that register is free
  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |-> (!out_tvalid || out_tready))
    else $error("result loaded over a pending one");

  // second word of a straddling pixel is written right after the first
  a_wr_order: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.wr_hi |-> $past(cmd.wr_lo))
    else $error("upper word written without lower word");

  // no request is taken while the store is being cleared
  a_clr_block: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.clr |-> !in_tready)
    else $error("request accepted during clearing pass");

  // one request at a time
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("second request accepted while busy");

endmodule

`default_nettype wire

// File: rtl/core/ppfa_dp.sv
`default_nettype none

module ppfa_dp import ppfa_pkg::*; #(
  parameter int unsigned MEM_WORDS = MEM_WORDS_DEF,
  parameter int unsigned MAX_DIM   = MAX_DIM_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  input  wire logic                  in_cmd,
  input  wire logic [X_W-1:0]        in_x,
  input  wire logic [Y_W-1:0]        in_y,
  input  wire logic [PIX_W-1:0]      in_value,
  input  wire ppfa_cmd_t             cmd,
  output ppfa_stat_t                 st,
  output logic [ST_W-1:0]            out_status,
  output logic [PIX_W-1:0]           out_pixel
);

  localparam int unsigned AW = (MEM_WORDS > 1) ? $clog2(MEM_WORDS) : 1;
  localparam logic [31:0] MAX_DIM_L = 32'(MAX_DIM);

  logic [DIM_W-1:0] width_r, height_r;
  logic [FMT_W-1:0] fmt_r;

  logic [DIM_W-1:0] eff_w, eff_h, eff_w_r, eff_h_r, rw, rw_r;
  logic [17:0]      row_bits;

  logic             cmd_r;
  logic [X_W-1:0]   x_r;
  logic [Y_W-1:0]   y_r;
  logic [PIX_W-1:0] v_r;

  logic [OFF_W-1:0] off;
  logic [2:0]       sub;
  logic [PROD_W-1:0] prod_r;
  logic             oof_r, span_r;
  logic [11:0]      off_word_r;
  logic [4:0]       bitpos_r;
  logic [PIX_W-1:0] mask_r;

  logic [IDXW-1:0]  idx0, last_idx;
  logic             beyond;
  logic [AW-1:0]    idx0_r, idx1;
  logic [ST_W-1:0]  res_status_r;
  logic [PIX_W-1:0] res_pix_r;

  logic [PIX_W-1:0] mem [MEM_WORDS];
  logic [PIX_W-1:0] rdata_r, w0_r, nw1_r;
  logic [AW-1:0]    clr_cnt_r;

  logic             mem_we, rd_en;
  logic [AW-1:0]    wa, ra;
  logic [PIX_W-1:0] wd;

  logic [63:0]      pair, pmask, npair, shifted;
  logic [PIX_W-1:0] rd_val;

  logic [ST_W-1:0]  out_status_r;
  logic [PIX_W-1:0] out_pix_r;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= '0;
      height_r <= '0;
      fmt_r    <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_WIDTH:  width_r  <= cfg_data[DIM_W-1:0];
        CFG_HEIGHT: height_r <= cfg_data[DIM_W-1:0];
        CFG_FORMAT: fmt_r    <= cfg_data[FMT_W-1:0];
        default: ;
      endcase
    end
  end

  // clamped dimensions and padded row length
  always_comb begin
    eff_w = (32'(width_r) > MAX_DIM_L) ? MAX_DIM_L[DIM_W-1:0] : width_r;
    eff_h = (32'(height_r) > MAX_DIM_L) ? MAX_DIM_L[DIM_W-1:0] : height_r;
    unique case (fmt_r)
      FMT_1BPP:  row_bits = 18'(eff_w);
      FMT_4BPP:  row_bits = 18'(eff_w) << 2;
      FMT_8BPP:  row_bits = 18'(eff_w) << 3;
      FMT_16BPP: row_bits = 18'(eff_w) << 4;
      FMT_24BPP: row_bits = (18'(eff_w) << 4) + (18'(eff_w) << 3);
      default:   row_bits = 18'(eff_w) << 5;
    endcase
    rw = DIM_W'((row_bits + 18'd31) >> 5);
  end

  always_ff @(posedge clk) begin
    eff_w_r <= eff_w;
    eff_h_r <= eff_h;
    rw_r    <= rw;
  end

  // request capture
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      cmd_r <= in_cmd;
      x_r   <= in_x;
      y_r   <= in_y;
      v_r   <= in_value;
    end
  end

  // byte offset in the row and bit position of the pixel
  always_comb begin
    sub = 3'd0;
    unique case (fmt_r)
      FMT_1BPP: begin
        off = OFF_W'(x_r >> 3);
        sub = 3'd7 - x_r[2:0];
      end
      FMT_4BPP: begin
        off = OFF_W'(x_r >> 1);
        sub = x_r[0] ? 3'd0 : 3'd4;
      end
      FMT_8BPP:  off = OFF_W'(x_r);
      FMT_16BPP: off = OFF_W'(x_r) << 1;
      FMT_24BPP: off = (OFF_W'(x_r) << 1) + OFF_W'(x_r);
      default:   off = OFF_W'(x_r) << 2;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.calc) begin
      prod_r     <= PROD_W'(y_r) * PROD_W'(rw_r);
      oof_r      <= ({1'b0, x_r} >= eff_w_r) || ({1'b0, y_r} >= eff_h_r);
      off_word_r <= off[OFF_W-1:2];
      bitpos_r   <= {off[1:0], 3'b000} + {2'b00, sub};
      mask_r     <= fmt_mask(fmt_r);
      span_r     <= (fmt_r == FMT_24BPP) && off[1];
    end
  end

  // word index and range check
  always_comb begin
    idx0     = IDXW'(prod_r) + IDXW'(off_word_r);
    last_idx = idx0 + IDXW'(span_r);
    beyond   = last_idx >= IDXW'(MEM_WORDS);
  end

  always_ff @(posedge clk) begin
    if (cmd.check) begin
      idx0_r       <= idx0[AW-1:0];
      res_pix_r    <= '0;
      res_status_r <= oof_r ? STATUS_OUTSIDE : (beyond ? STATUS_BEYOND : STATUS_OK);
    end else if (cmd.modify) begin
      res_pix_r <= (cmd_r == CMD_WRITE) ? '0 : rd_val;
    end
  end

  // pixel extract and merge over the word pair
  always_comb begin
    pair    = {span_r ? rdata_r : 32'h0, w0_r};
    shifted = pair >> bitpos_r;
    rd_val  = shifted[PIX_W-1:0] & mask_r;
    pmask   = {32'h0, mask_r} << bitpos_r;
    npair   = (pair & ~pmask) | ({32'h0, v_r & mask_r} << bitpos_r);
  end

  always_ff @(posedge clk) begin
    if (cmd.cap_lo) w0_r <= rdata_r;
    if (cmd.modify) nw1_r <= npair[63:32];
  end

  // frame store
  always_comb begin
    idx1   = idx0_r + AW'(1);
    rd_en  = cmd.rd_lo | cmd.rd_hi;
    ra     = cmd.rd_hi ? idx1 : idx0_r;
    mem_we = cmd.clr | cmd.wr_lo | cmd.wr_hi;
    if (cmd.clr) begin
      wa = clr_cnt_r;
      wd = '0;
    end else if (cmd.wr_hi) begin
      wa = idx1;
      wd = nw1_r;
    end else begin
      wa = idx0_r;
      wd = npair[PIX_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[wa] <= wd;
    if (rd_en) rdata_r <= mem[ra];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r <= '0;
    end else if (cmd.clr) begin
      clr_cnt_r <= clr_cnt_r + AW'(1);
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_status_r <= res_status_r;
      out_pix_r    <= res_pix_r;
    end
  end

  assign st.clr_last = clr_cnt_r == AW'(MEM_WORDS - 1);
  assign st.err      = oof_r || beyond;
  assign st.span     = span_r;
  assign st.is_write = cmd_r == CMD_WRITE;

  assign out_status = out_status_r;
  assign out_pixel  = out_pix_r;

endmodule

`default_nettype wire

// File: rtl/core/ppfa_ctrl.sv
`default_nettype none

module ppfa_ctrl import ppfa_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_tvalid,
  output logic            in_tready,
  output logic            out_tvalid,
  input  wire logic       out_tready,
  input  wire ppfa_stat_t st,
  output ppfa_cmd_t       cmd
);

  localparam logic [3:0] S_CLEAR  = 4'd0;
  localparam logic [3:0] S_IDLE   = 4'd1;
  localparam logic [3:0] S_ADDR   = 4'd2;
  localparam logic [3:0] S_CHECK  = 4'd3;
  localparam logic [3:0] S_READ0  = 4'd4;
  localparam logic [3:0] S_READ1  = 4'd5;
  localparam logic [3:0] S_MODIFY = 4'd6;
  localparam logic [3:0] S_WRITE1 = 4'd7;
  localparam logic [3:0] S_RESULT = 4'd8;

  logic [3:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       slot_free;

  assign slot_free = !out_valid_r || out_tready;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_CLEAR: begin
        cmd.clr = 1'b1;
        if (st.clr_last) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.capture = 1'b1;
          state_nxt   = S_ADDR;
        end
      end
      S_ADDR: begin
        cmd.calc  = 1'b1;
        state_nxt = S_CHECK;
      end
      S_CHECK: begin
        cmd.check = 1'b1;
        state_nxt = st.err ? S_RESULT : S_READ0;
      end
      S_READ0: begin
        cmd.rd_lo = 1'b1;
        state_nxt = S_READ1;
      end
      S_READ1: begin
        cmd.cap_lo = 1'b1;
        cmd.rd_hi  = st.span;
        state_nxt  = S_MODIFY;
      end
      S_MODIFY: begin
        cmd.modify = 1'b1;
        cmd.wr_lo  = st.is_write;
        state_nxt  = (st.is_write && st.span) ? S_WRITE1 : S_RESULT;
      end
      S_WRITE1: begin
        cmd.wr_hi = 1'b1;
        state_nxt = S_RESULT;
      end
      S_RESULT: begin
        if (slot_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.load_out) out_valid_nxt = 1'b1;
    else if (out_tready) out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_tready  = state_r == S_IDLE;
  assign out_tvalid = out_valid_r;

endmodule

`default_nettype wire
